[hw/rtl/sbpm_pkg.sv]
// Shared types, codes and constants of the servo bus packet master.
// Used by the top level, front, queue and back modules; depends on nothing.
package sbpm_pkg;

  localparam int unsigned MAX_PARAMS_DEF      = 64;
  localparam int unsigned MAX_REPLY_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH         = 4;
  localparam int unsigned PC_W                = 7;
  localparam int unsigned TICK_W              = 10;
  localparam int unsigned CFG_IDX_W           = 1;
  localparam int unsigned HDR_BYTES           = 5;

  localparam logic [7:0]        SYNC_BYTE      = 8'hFF;
  localparam logic [TICK_W-1:0] ECHO_TO_RESET  = 10'd500;
  localparam logic [TICK_W-1:0] REPLY_TO_RESET = 10'd20;
  localparam logic [TICK_W-1:0] TICK_MAX       = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT = 1'd1;

  localparam logic [2:0] HS_SYNC0 = 3'd0;
  localparam logic [2:0] HS_SYNC1 = 3'd1;
  localparam logic [2:0] HS_ID    = 3'd2;
  localparam logic [2:0] HS_LEN   = 3'd3;
  localparam logic [2:0] HS_ERR   = 3'd4;
  localparam logic [2:0] HS_DATA  = 3'd5;

  typedef enum logic [1:0] {OP_START, OP_PARAM, OP_RX_BYTE, OP_TICK} op_t;
  typedef enum logic [1:0] {PH_IDLE, PH_PARAMS, PH_ECHO, PH_REPLY} phase_t;
  typedef enum logic [0:0] {KIND_TX, KIND_DONE} kind_t;
  typedef enum logic [1:0] {ST_OK, ST_SERVO_ERR, ST_NO_REPLY} status_t;
  typedef enum logic [1:0] {ECHO_MATCH, ECHO_MISMATCH, ECHO_TIMEOUT} echo_t;
  typedef enum logic [1:0] {JOB_HDR, JOB_PARAM, JOB_DONE} job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  csum;
    logic        with_csum;
    status_t     status;
    echo_t       echo;
    logic [7:0]  err;
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/sbpm_if.sv]
// Channel interfaces of the servo bus packet master: command, result and
// configuration write channels. Payload widths follow the package.
interface sbpm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] servo_id;
  logic [7:0] instruction;
  logic [6:0] param_count;
  logic [2:0] reply_length;
  logic [7:0] data_byte;

  modport source (output valid, opcode, servo_id, instruction, param_count,
                  reply_length, data_byte, input ready);
  modport sink (input valid, opcode, servo_id, instruction, param_count,
                reply_length, data_byte, output ready);
endinterface

interface sbpm_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [1:0]  status;
  logic [1:0]  echo_result;
  logic [7:0]  error_byte;
  logic [31:0] reply_value;

  modport source (output valid, kind, tx_byte, tx_last, status, echo_result,
                  error_byte, reply_value, input ready);
  modport sink (input valid, kind, tx_byte, tx_last, status, echo_result,
                error_byte, reply_value, output ready);
endinterface

interface sbpm_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/servo_bus_packet_master.sv]
// Servo bus packet master top level: front part, job queue and back part.
// Depends on sbpm_pkg, sbpm_if, sbpm_front, sbpm_queue and sbpm_back.
// With the queue empty, an item's job is written into the queue and then
// registered as its first result in the back part's output register; otherwise it
// waits until the results of the jobs queued before it have been transferred. A
// start item yields five or six results and a parameter item one or two, delivered
// one per cycle by the back part while the receiver takes them; the front takes an
// item every cycle while the four-entry queue has room. Reset is synchronous and
// returns the timeouts to 500 and 20 ticks and the transaction to idle.
module servo_bus_packet_master #(
  parameter int unsigned MAX_PARAMS      = sbpm_pkg::MAX_PARAMS_DEF,
  parameter int unsigned MAX_REPLY_BYTES = sbpm_pkg::MAX_REPLY_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  sbpm_cmd_if.sink   cmd,
  sbpm_rsp_if.source rsp,
  sbpm_cfg_if.sink   cfg
);
  import sbpm_pkg::*;

  logic    push, pop;
  job_t    push_job, head;
  q_stat_t q_stat;

  sbpm_front #(
    .MAX_PARAMS      (MAX_PARAMS),
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  sbpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sbpm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == KIND_DONE) |->
      (rsp.tx_byte == 8'd0 && !rsp.tx_last && rsp.status != 2'd3
       && rsp.echo_result != 2'd3))
    else $error("malformed finish result");

  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == KIND_TX) |->
      (rsp.status == ST_OK && rsp.echo_result == ECHO_MATCH
       && rsp.error_byte == 8'd0 && rsp.reply_value == 32'd0))
    else $error("transmit result carries finish fields");

endmodule

[hw/rtl/sbpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module sbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sbpm_front.sv]
// Front part: accepts and classifies command items, tracks the transaction
// phase, checks the echo and parses the reply. Uses sbpm_pkg and sbpm_ram.
module sbpm_front #(
  parameter int unsigned MAX_PARAMS      = sbpm_pkg::MAX_PARAMS_DEF,
  parameter int unsigned MAX_REPLY_BYTES = sbpm_pkg::MAX_REPLY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sbpm_cmd_if.sink          cmd,
  sbpm_cfg_if.sink          cfg,
  input  sbpm_pkg::q_stat_t q_stat,
  output logic              push,
  output sbpm_pkg::job_t    job
);
  import sbpm_pkg::*;

  localparam int unsigned AW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned POS_W = $clog2(MAX_PARAMS + 7);

  phase_t              phase, phase_next;
  logic [PC_W-1:0]     param_total, param_total_next;
  logic [PC_W-1:0]     params_left, params_left_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [7:0]          id_r, id_r_next, len_r, len_r_next, ins_r, ins_r_next;
  logic [7:0]          csum_r, csum_r_next;
  logic [POS_W-1:0]    echo_pos, echo_pos_next;
  echo_t               echo_flag, echo_flag_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [TICK_W-1:0]   echo_to, reply_to;
  logic [2:0]          header_stage, header_stage_next;
  logic [2:0]          reply_got, reply_got_next;
  logic [2:0]          reply_want, reply_want_next;
  logic [31:0]         reply_accum, reply_accum_next;

  logic                acc, is_start, is_param, is_rx, is_tick;
  logic [PC_W-1:0]     cnt_sat, left_dec;
  logic [2:0]          want_sat, got_inc;
  logic [7:0]          len_start, sum_start, sum_param, exp_byte, ram_rdata;
  logic [POS_W-1:0]    last_pos;
  logic                rx_match;
  logic [TICK_W-1:0]   tick_inc;
  logic [31:0]         accum_new;
  logic                ev_param, param_fin, ev_echo_rx, ev_echo_tick;
  logic                ev_reply_rx, ev_reply_tick, enter_reply, finish;
  logic                done_err, done_ok0, done_data, done_tick;

  assign cmd.ready = !q_stat.full;
  assign cfg.ready = 1'b1;

  assign acc      = cmd.valid && cmd.ready;
  assign is_start = acc && (cmd.opcode == OP_START);
  assign is_param = acc && (cmd.opcode == OP_PARAM);
  assign is_rx    = acc && (cmd.opcode == OP_RX_BYTE);
  assign is_tick  = acc && (cmd.opcode == OP_TICK);

  assign cnt_sat   = (cmd.param_count > PC_W'(MAX_PARAMS)) ? PC_W'(MAX_PARAMS)
                                                           : cmd.param_count;
  assign want_sat  = (cmd.reply_length > 3'(MAX_REPLY_BYTES)) ? 3'(MAX_REPLY_BYTES)
                                                              : cmd.reply_length;
  assign len_start = 8'(cnt_sat) + 8'd2;
  assign sum_start = cmd.servo_id + len_start + cmd.instruction;
  assign sum_param = running_sum + cmd.data_byte;
  assign left_dec  = params_left - PC_W'(1);
  assign last_pos  = POS_W'(param_total) + POS_W'(HDR_BYTES);
  assign tick_inc  = (tick_count == TICK_MAX) ? tick_count : tick_count + TICK_W'(1);
  assign got_inc   = reply_got + 3'd1;
  assign accum_new = reply_got[2] ? reply_accum
                   : reply_accum | (32'(cmd.data_byte) << {reply_got[1:0], 3'b000});

  always_comb begin
    priority if (echo_pos == POS_W'(0) || echo_pos == POS_W'(1)) begin
      exp_byte = SYNC_BYTE;
    end else if (echo_pos == POS_W'(2)) begin
      exp_byte = id_r;
    end else if (echo_pos == POS_W'(3)) begin
      exp_byte = len_r;
    end else if (echo_pos == POS_W'(4)) begin
      exp_byte = ins_r;
    end else if (echo_pos == last_pos) begin
      exp_byte = csum_r;
    end else begin
      exp_byte = ram_rdata;
    end
  end

  assign rx_match = (cmd.data_byte == exp_byte);

  assign ev_param      = is_param && (phase == PH_PARAMS);
  assign param_fin     = ev_param && (left_dec == '0);
  assign ev_echo_rx    = is_rx && (phase == PH_ECHO);
  assign ev_echo_tick  = is_tick && (phase == PH_ECHO);
  assign ev_reply_rx   = is_rx && (phase == PH_REPLY);
  assign ev_reply_tick = is_tick && (phase == PH_REPLY);
  assign enter_reply   = (ev_echo_rx && (!rx_match || echo_pos == last_pos))
                      || (ev_echo_tick && (tick_count >= echo_to));
  assign done_err  = ev_reply_rx && (header_stage == HS_ERR) && (cmd.data_byte != 8'd0);
  assign done_ok0  = ev_reply_rx && (header_stage == HS_ERR) && (cmd.data_byte == 8'd0)
                  && (reply_want == 3'd0);
  assign done_data = ev_reply_rx && (header_stage >= HS_DATA) && (got_inc >= reply_want);
  assign done_tick = ev_reply_tick && (tick_inc >= reply_to);
  assign finish    = done_err || done_ok0 || done_data || done_tick;

  always_comb begin
    phase_next = phase;
    priority if (is_start) begin
      phase_next = (cnt_sat == '0) ? PH_ECHO : PH_PARAMS;
    end else if (param_fin) begin
      phase_next = PH_ECHO;
    end else if (enter_reply) begin
      phase_next = PH_REPLY;
    end else if (finish) begin
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    param_total_next  = param_total;
    params_left_next  = params_left;
    running_sum_next  = running_sum;
    id_r_next         = id_r;
    len_r_next        = len_r;
    ins_r_next        = ins_r;
    csum_r_next       = csum_r;
    echo_pos_next     = echo_pos;
    echo_flag_next    = echo_flag;
    tick_count_next   = tick_count;
    header_stage_next = header_stage;
    reply_got_next    = reply_got;
    reply_want_next   = reply_want;
    reply_accum_next  = reply_accum;
    push              = 1'b0;
    job               = '0;
    priority if (is_start) begin
      param_total_next  = cnt_sat;
      params_left_next  = cnt_sat;
      running_sum_next  = sum_start;
      id_r_next         = cmd.servo_id;
      len_r_next        = len_start;
      ins_r_next        = cmd.instruction;
      csum_r_next       = ~sum_start;
      echo_pos_next     = '0;
      echo_flag_next    = ECHO_MATCH;
      tick_count_next   = '0;
      header_stage_next = HS_SYNC0;
      reply_got_next    = '0;
      reply_want_next   = want_sat;
      reply_accum_next  = '0;
      push              = 1'b1;
      job.kind          = JOB_HDR;
      job.b0            = cmd.servo_id;
      job.b1            = len_start;
      job.b2            = cmd.instruction;
      job.csum          = ~sum_start;
      job.with_csum     = (cnt_sat == '0);
    end else if (ev_param) begin
      running_sum_next = sum_param;
      params_left_next = left_dec;
      push             = 1'b1;
      job.kind         = JOB_PARAM;
      job.b0           = cmd.data_byte;
      job.csum         = ~sum_param;
      job.with_csum    = param_fin;
      if (param_fin) begin
        csum_r_next     = ~sum_param;
        echo_pos_next   = '0;
        tick_count_next = '0;
      end
    end else if (ev_echo_rx || ev_echo_tick) begin
      if (ev_echo_rx && !rx_match) begin
        echo_flag_next = ECHO_MISMATCH;
      end else if (ev_echo_rx) begin
        echo_pos_next = echo_pos + POS_W'(1);
      end else if (tick_count >= echo_to) begin
        echo_flag_next = ECHO_TIMEOUT;
      end else begin
        tick_count_next = tick_count + TICK_W'(1);
      end
      if (enter_reply) begin
        tick_count_next   = '0;
        header_stage_next = HS_SYNC0;
        reply_accum_next  = '0;
        reply_got_next    = '0;
      end
    end else if (ev_reply_rx) begin
      priority case (header_stage)
        HS_SYNC0: begin
          if (cmd.data_byte == SYNC_BYTE) begin
            header_stage_next = HS_SYNC1;
          end
        end
        HS_SYNC1: begin
          header_stage_next = (cmd.data_byte == SYNC_BYTE) ? HS_ID : HS_SYNC0;
        end
        HS_ID:  header_stage_next = HS_LEN;
        HS_LEN: header_stage_next = HS_ERR;
        HS_ERR: begin
          if (!done_err && !done_ok0) begin
            header_stage_next = HS_DATA;
          end
        end
        default: begin
          reply_accum_next = accum_new;
          reply_got_next   = got_inc;
        end
      endcase
      if (done_err || done_ok0 || done_data) begin
        push       = 1'b1;
        job.kind   = JOB_DONE;
        job.status = done_err ? ST_SERVO_ERR : ST_OK;
        job.echo   = echo_flag;
        job.err    = done_err ? cmd.data_byte : 8'd0;
        job.value  = done_data ? accum_new : 32'd0;
      end
    end else if (ev_reply_tick) begin
      tick_count_next = tick_inc;
      if (done_tick) begin
        push       = 1'b1;
        job.kind   = JOB_DONE;
        job.status = ST_NO_REPLY;
        job.echo   = echo_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      param_total  <= '0;
      params_left  <= '0;
      running_sum  <= '0;
      echo_pos     <= '0;
      echo_flag    <= ECHO_MATCH;
      tick_count   <= '0;
      header_stage <= HS_SYNC0;
      reply_got    <= '0;
      reply_want   <= '0;
      reply_accum  <= '0;
      echo_to      <= ECHO_TO_RESET;
      reply_to     <= REPLY_TO_RESET;
    end else begin
      phase        <= phase_next;
      param_total  <= param_total_next;
      params_left  <= params_left_next;
      running_sum  <= running_sum_next;
      echo_pos     <= echo_pos_next;
      echo_flag    <= echo_flag_next;
      tick_count   <= tick_count_next;
      header_stage <= header_stage_next;
      reply_got    <= reply_got_next;
      reply_want   <= reply_want_next;
      reply_accum  <= reply_accum_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_ECHO_TIMEOUT:  echo_to  <= cfg.data;
          REG_REPLY_TIMEOUT: reply_to <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_r_next;
    len_r  <= len_r_next;
    ins_r  <= ins_r_next;
    csum_r <= csum_r_next;
  end

  sbpm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PARAMS)
  ) u_sent_store (
    .clk   (clk),
    .we    (ev_param),
    .waddr (AW'(param_total - params_left)),
    .wdata (cmd.data_byte),
    .raddr (AW'(echo_pos_next - POS_W'(HDR_BYTES))),
    .rdata (ram_rdata)
  );

endmodule

[hw/rtl/sbpm_queue.sv]
// Short job queue between the front and back parts.
// Uses sbpm_pkg for the job and status types.
module sbpm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbpm_pkg::job_t    push_job,
  input  logic              pop,
  output sbpm_pkg::job_t    head,
  output sbpm_pkg::q_stat_t stat
);
  import sbpm_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[hw/rtl/sbpm_back.sv]
// Back part: expands queued jobs into result transfers, one per cycle while the
// receiver takes them, through an output register. Uses sbpm_pkg.
module sbpm_back (
  input  logic              clk,
  input  logic              rst,
  input  sbpm_pkg::job_t    head,
  input  sbpm_pkg::q_stat_t q_stat,
  output logic              pop,
  sbpm_rsp_if.source        rsp
);
  import sbpm_pkg::*;

  logic [2:0]  step, step_next;
  logic        emit, last_step;
  kind_t       r_kind;
  logic [7:0]  r_byte;
  logic        r_last;

  assign emit = !q_stat.empty && (!rsp.valid || rsp.ready);

  always_comb begin
    r_kind = KIND_TX;
    r_byte = 8'd0;
    r_last = 1'b0;
    last_step = 1'b1;
    unique case (head.kind)
      JOB_HDR: begin
        last_step = (step == (head.with_csum ? 3'd5 : 3'd4));
        unique case (step)
          3'd0, 3'd1: r_byte = SYNC_BYTE;
          3'd2: r_byte = head.b0;
          3'd3: r_byte = head.b1;
          3'd4: r_byte = head.b2;
          default: begin
            r_byte = head.csum;
            r_last = 1'b1;
          end
        endcase
      end
      JOB_PARAM: begin
        last_step = (step == (head.with_csum ? 3'd1 : 3'd0));
        if (step == 3'd0) begin
          r_byte = head.b0;
        end else begin
          r_byte = head.csum;
          r_last = 1'b1;
        end
      end
      default: begin
        r_kind = KIND_DONE;
      end
    endcase
  end

  assign pop       = emit && last_step;
  assign step_next = pop ? 3'd0 : step + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      rsp.valid <= 1'b0;
    end else if (emit) begin
      step            <= step_next;
      rsp.valid       <= 1'b1;
      rsp.kind        <= r_kind;
      rsp.tx_byte     <= r_byte;
      rsp.tx_last     <= r_last;
      rsp.status      <= (r_kind == KIND_DONE) ? head.status : ST_OK;
      rsp.echo_result <= (r_kind == KIND_DONE) ? head.echo : ECHO_MATCH;
      rsp.error_byte  <= (r_kind == KIND_DONE) ? head.err : 8'd0;
      rsp.reply_value <= (r_kind == KIND_DONE) ? head.value : 32'd0;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule
